### rtl/frp_pkg.sv
// Shared types, constants and codes for the FASTQ record parser.
package frp_pkg;

    // Line length counters and the reported sequence length share this width
    localparam int LENGTH_BITS = 20;

    // Characters the parser reacts to
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Field tags
    localparam logic [2:0] TAG_NONE      = 3'd0;
    localparam logic [2:0] TAG_HEADER    = 3'd1;
    localparam logic [2:0] TAG_SEQUENCE  = 3'd2;
    localparam logic [2:0] TAG_SEPARATOR = 3'd3;
    localparam logic [2:0] TAG_QUALITY   = 3'd4;

    // Config port: one register, index taken from paddr[2]
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_HAS_QUALITY = 1'b0;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [7:0]             byte_out;
        logic [2:0]             field_tag;
        logic                   record_end;
        logic                   record_status;
        logic [LENGTH_BITS-1:0] sequence_length;
    } t_out_beat;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;        // last byte of the stream
        logic       brk;        // line break (CR, LF not paired with a CR)
        logic       pair_lf;    // LF closing a CR LF pair: no effect
        logic       hdr_start;  // '@' at the start of a line
    } t_cls;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_SEEK = 5'b00001,
        PH_HEAD = 5'b00010,
        PH_SEQ  = 5'b00100,
        PH_SEP  = 5'b01000,
        PH_QUAL = 5'b10000
    } t_phase;

endpackage

### rtl/fastq_record_parser_core.sv
// Top level of the FASTQ record parser: front, queue, back and config register.
//
// Input channel (i_valid / o_ready / i_data): one beat per byte of FASTQ text,
// with end_of_stream set on the last byte. Output channel (o_valid / i_ready /
// o_data): one beat per input byte, the byte passed through with its field
// tag, and on the byte that closes a record the record_end flag, the length
// check status and the saturated sequence length.
// An accepted byte is registered in the queue and then in the output register;
// throughput is one byte per clock while i_ready is high, set by the phase
// machine in the back end. A two-entry queue between the classifying front
// and the back lets the input keep flowing while an output beat waits.
// When the receiver holds i_ready low the output beat holds, the queue fills,
// and o_ready drops once both queue entries are taken.
// Reset (synchronous, i_rst_n low) empties the queue and output, returns the
// parser to header search and sets has_quality to 1.
// Config: APB register has_quality at byte address 0, written when idle.
module fastq_record_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  frp_pkg::t_in_beat              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output frp_pkg::t_out_beat             o_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frp_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic          r_has_quality;
    logic          q_ready;
    logic          push;
    frp_pkg::t_cls front_cls;
    logic          q_valid;
    frp_pkg::t_cls q_cls;
    logic          pop;
    logic          reg_hit;

    // Config register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == frp_pkg::REG_HAS_QUALITY);
    assign prdata  = reg_hit ? {31'd0, r_has_quality} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_quality <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_has_quality <= pwdata[0];
        end
    end

    frp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_beat    (i_data),
        .o_ready   (o_ready),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cls     (front_cls)
    );

    frp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cls      (front_cls),
        .o_not_full (q_ready),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_cls      (q_cls)
    );

    frp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_has_quality (r_has_quality),
        .i_q_valid     (q_valid),
        .i_cls         (q_cls),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_beat        (o_data)
    );

endmodule

### rtl/frp_front.sv
// Front end: accepts stream bytes and classifies line breaks and header starts.
module frp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  frp_pkg::t_in_beat i_beat,
    output logic             o_ready,
    input  logic             i_q_ready,
    output logic             o_push,
    output frp_pkg::t_cls    o_cls
);

    logic r_at_line_start;
    logic r_after_cr;
    logic n_at_line_start;
    logic n_after_cr;
    logic is_cr;
    logic is_lf;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    assign is_cr = (i_beat.data_byte == frp_pkg::CH_CR);
    assign is_lf = (i_beat.data_byte == frp_pkg::CH_LF);

    // Classification of the current byte
    always_comb begin
        o_cls.data_byte = i_beat.data_byte;
        o_cls.eos       = i_beat.end_of_stream;
        o_cls.pair_lf   = r_after_cr && is_lf;
        o_cls.brk       = !(r_after_cr && is_lf) && (is_cr || is_lf);
        o_cls.hdr_start = r_at_line_start && (i_beat.data_byte == frp_pkg::CH_AT);
    end

    // Line position tracking
    always_comb begin
        n_at_line_start = r_at_line_start;
        n_after_cr      = r_after_cr;
        if (o_push) begin
            if (o_cls.pair_lf) begin
                n_after_cr = 1'b0;
            end else begin
                n_after_cr      = is_cr;
                n_at_line_start = o_cls.brk;
            end
            if (i_beat.end_of_stream) begin
                n_at_line_start = 1'b1;
                n_after_cr      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_after_cr      <= 1'b0;
        end else begin
            r_at_line_start <= n_at_line_start;
            r_after_cr      <= n_after_cr;
        end
    end

endmodule

### rtl/frp_queue.sv
// Short queue of classified bytes between front and back.
module frp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  frp_pkg::t_cls i_cls,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_valid,
    output frp_pkg::t_cls o_cls
);

    frp_pkg::t_cls                 r_mem [frp_pkg::QUEUE_DEPTH];
    logic [frp_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [frp_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [frp_pkg::QUEUE_CW-1:0]  r_count;
    logic [frp_pkg::QUEUE_CW-1:0]  n_count;

    localparam logic [frp_pkg::QUEUE_CW-1:0] FULL_COUNT =
        frp_pkg::QUEUE_CW'(frp_pkg::QUEUE_DEPTH);

    assign o_not_full = (r_count != FULL_COUNT);
    assign o_valid    = (r_count != '0);
    assign o_cls      = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

### rtl/frp_back.sv
// Back end: record phase machine, length counters and output register.
module frp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_has_quality,
    input  logic                 i_q_valid,
    input  frp_pkg::t_cls        i_cls,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output frp_pkg::t_out_beat   o_beat
);

    localparam logic [frp_pkg::LENGTH_BITS-1:0] COUNT_MAX = '1;

    frp_pkg::t_phase                r_phase;
    frp_pkg::t_phase                n_phase;
    logic [frp_pkg::LENGTH_BITS-1:0] r_seq;
    logic [frp_pkg::LENGTH_BITS-1:0] n_seq;
    logic [frp_pkg::LENGTH_BITS-1:0] r_qual;
    logic [frp_pkg::LENGTH_BITS-1:0] n_qual;
    logic                            r_o_valid;
    frp_pkg::t_out_beat              r_beat;
    frp_pkg::t_out_beat              n_beat;

    assign o_pop   = i_q_valid && (!r_o_valid || i_ready);
    assign o_valid = r_o_valid;
    assign o_beat  = r_beat;

    // Phase transitions, counting and record completion
    always_comb begin
        n_phase                = r_phase;
        n_seq                  = r_seq;
        n_qual                 = r_qual;
        n_beat.byte_out        = i_cls.data_byte;
        n_beat.field_tag       = frp_pkg::TAG_NONE;
        n_beat.record_end      = 1'b0;
        n_beat.record_status   = 1'b0;
        n_beat.sequence_length = '0;

        if (i_cls.pair_lf) begin
            // second half of CR LF: nothing changes
        end else if (i_cls.brk) begin
            case (r_phase)
                frp_pkg::PH_HEAD: begin
                    n_phase = frp_pkg::PH_SEQ;
                end
                frp_pkg::PH_SEQ: begin
                    n_phase = frp_pkg::PH_SEP;
                end
                frp_pkg::PH_SEP: begin
                    if (i_has_quality) begin
                        n_phase = frp_pkg::PH_QUAL;
                    end else begin
                        n_beat.record_end      = 1'b1;
                        n_beat.sequence_length = r_seq;
                        n_phase                = frp_pkg::PH_SEEK;
                    end
                end
                frp_pkg::PH_QUAL: begin
                    n_beat.record_end      = 1'b1;
                    n_beat.sequence_length = r_seq;
                    n_beat.record_status   = (r_qual != r_seq);
                    n_phase                = frp_pkg::PH_SEEK;
                end
                default: begin
                    n_phase = frp_pkg::PH_SEEK;
                end
            endcase
        end else begin
            case (r_phase)
                frp_pkg::PH_HEAD: begin
                    n_beat.field_tag = frp_pkg::TAG_HEADER;
                end
                frp_pkg::PH_SEQ: begin
                    n_beat.field_tag = frp_pkg::TAG_SEQUENCE;
                    n_seq = (r_seq == COUNT_MAX) ? r_seq : r_seq + 1'b1;
                end
                frp_pkg::PH_SEP: begin
                    n_beat.field_tag = frp_pkg::TAG_SEPARATOR;
                end
                frp_pkg::PH_QUAL: begin
                    n_beat.field_tag = frp_pkg::TAG_QUALITY;
                    n_qual = (r_qual == COUNT_MAX) ? r_qual : r_qual + 1'b1;
                end
                default: begin
                    if (i_cls.hdr_start) begin
                        n_beat.field_tag = frp_pkg::TAG_HEADER;
                        n_phase          = frp_pkg::PH_HEAD;
                        n_seq            = '0;
                        n_qual           = '0;
                    end
                end
            endcase
        end

        // End of stream closes an open record and clears state
        if (i_cls.eos) begin
            if (!n_beat.record_end && (n_phase != frp_pkg::PH_SEEK)) begin
                n_beat.record_end      = 1'b1;
                n_beat.sequence_length = n_seq;
                n_beat.record_status   = i_has_quality && (n_qual != n_seq);
            end
            n_phase = frp_pkg::PH_SEEK;
            n_seq   = '0;
            n_qual  = '0;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= frp_pkg::PH_SEEK;
            r_seq   <= '0;
            r_qual  <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_qual  <= n_qual;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_pop) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= n_beat;
        end
    end

endmodule

### rtl/frp_checker.sv
// Port-level checker for the FASTQ record parser, bound to the top level.
module frp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  frp_pkg::t_in_beat              i_data,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  frp_pkg::t_out_beat             o_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frp_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    input  logic [31:0]                    prdata,
    input  logic                           pready
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // Status and length are zero unless the beat closes a record
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.record_end |->
            !o_data.record_status && (o_data.sequence_length == '0))
        else $error("record fields set without record end");

    // Line terminators are never tagged
    a_term_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_data.byte_out == frp_pkg::CH_CR) ||
                    (o_data.byte_out == frp_pkg::CH_LF)) |->
            (o_data.field_tag == frp_pkg::TAG_NONE))
        else $error("terminator byte carries a field tag");

    // Field tag stays within the defined codes
    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.field_tag <= frp_pkg::TAG_QUALITY))
        else $error("field tag out of range");

endmodule

bind fastq_record_parser_core frp_checker u_frp_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the FASTQ record parser: byte stream in, tagged beats out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [frp_pkg::PADDR_W-1:0] HASQ_ADDR =
        frp_pkg::PADDR_W'(int'(frp_pkg::REG_HAS_QUALITY) * 4);

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    frp_pkg::t_in_beat           i_data = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    frp_pkg::t_out_beat          o_data;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [frp_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Bytes waiting to be sent, and tagged beats the parser still owes us
    frp_pkg::t_in_beat    text_stream[$];
    frp_pkg::t_out_beat   tagged_due[$];

    int                   mism_count = 0;
    int                   send_wait = 0;
    int                   stall_left = 0;
    bit                   idle_on = 1'b1;
    logic                 in_took = 1'b0;

    // Shadow copy of the parser state and its register
    frp_pkg::t_phase                 sh_phase = frp_pkg::PH_SEEK;
    logic                            sh_line_start = 1'b1;
    logic                            sh_after_cr = 1'b0;
    logic [frp_pkg::LENGTH_BITS-1:0] sh_seq_len = '0;
    logic [frp_pkg::LENGTH_BITS-1:0] sh_qual_len = '0;
    logic                            sh_has_qual = 1'b1;

    fastq_record_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        mism_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Predict the tagged beat for one accepted byte and advance the shadow state
    function automatic frp_pkg::t_out_beat parse_byte(frp_pkg::t_in_beat beat);
        frp_pkg::t_out_beat r;
        logic [7:0]         b;
        logic               brk;
        r = '0;
        b = beat.data_byte;
        r.byte_out = b;
        r.field_tag = frp_pkg::TAG_NONE;
        brk = (b == frp_pkg::CH_CR) || (b == frp_pkg::CH_LF);
        if (sh_after_cr && b == frp_pkg::CH_LF) begin
            sh_after_cr = 1'b0;
        end else begin
            sh_after_cr = (b == frp_pkg::CH_CR);
            if (brk) begin
                sh_line_start = 1'b1;
                case (sh_phase)
                    frp_pkg::PH_HEAD: sh_phase = frp_pkg::PH_SEQ;
                    frp_pkg::PH_SEQ:  sh_phase = frp_pkg::PH_SEP;
                    frp_pkg::PH_SEP: begin
                        if (sh_has_qual) begin
                            sh_phase = frp_pkg::PH_QUAL;
                        end else begin
                            r.record_end = 1'b1;
                            r.sequence_length = sh_seq_len;
                            sh_phase = frp_pkg::PH_SEEK;
                        end
                    end
                    frp_pkg::PH_QUAL: begin
                        r.record_end = 1'b1;
                        r.sequence_length = sh_seq_len;
                        r.record_status = (sh_qual_len != sh_seq_len);
                        sh_phase = frp_pkg::PH_SEEK;
                    end
                    default: sh_phase = frp_pkg::PH_SEEK;
                endcase
            end else begin
                case (sh_phase)
                    frp_pkg::PH_HEAD: r.field_tag = frp_pkg::TAG_HEADER;
                    frp_pkg::PH_SEQ: begin
                        r.field_tag = frp_pkg::TAG_SEQUENCE;
                        if (sh_seq_len != '1) sh_seq_len++;
                    end
                    frp_pkg::PH_SEP:  r.field_tag = frp_pkg::TAG_SEPARATOR;
                    frp_pkg::PH_QUAL: begin
                        r.field_tag = frp_pkg::TAG_QUALITY;
                        if (sh_qual_len != '1) sh_qual_len++;
                    end
                    default: begin
                        if (sh_line_start && b == frp_pkg::CH_AT) begin
                            r.field_tag = frp_pkg::TAG_HEADER;
                            sh_phase = frp_pkg::PH_HEAD;
                            sh_seq_len = '0;
                            sh_qual_len = '0;
                        end
                    end
                endcase
                sh_line_start = 1'b0;
            end
        end
        // End of stream closes any open record, then back to header search
        if (beat.end_of_stream) begin
            if (!r.record_end && sh_phase != frp_pkg::PH_SEEK) begin
                r.record_end = 1'b1;
                r.sequence_length = sh_seq_len;
                if (sh_has_qual) r.record_status = (sh_qual_len != sh_seq_len);
            end
            sh_phase = frp_pkg::PH_SEEK;
            sh_line_start = 1'b1;
            sh_after_cr = 1'b0;
            sh_seq_len = '0;
            sh_qual_len = '0;
        end
        return r;
    endfunction

    // Input driver: holds a beat until taken, then pops the next after a gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_took) begin
            i_valid <= 1'b1;
        end else if (send_wait > 0) begin
            i_valid <= 1'b0;
            send_wait--;
        end else if (text_stream.size() != 0) begin
            i_data <= text_stream.pop_front();
            i_valid <= 1'b1;
            send_wait = idle_on ? rand_gap() : 0;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Output sink: random stalls on i_ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left = rand_gap();
        end
    end

    // Monitor: predict on input beats, check output beats in order
    always @(posedge i_clk) begin
        frp_pkg::t_out_beat want;
        in_took <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) tagged_due.push_back(parse_byte(i_data));
        if (i_rst_n && o_valid && i_ready) begin
            if (tagged_due.size() == 0) begin
                flag_error($sformatf("output beat %h with nothing due", o_data));
            end else begin
                want = tagged_due.pop_front();
                if (o_data.byte_out !== want.byte_out)
                    flag_error($sformatf("byte_out %h, want %h",
                                         o_data.byte_out, want.byte_out));
                if (o_data.field_tag !== want.field_tag)
                    flag_error($sformatf("field_tag %0d, want %0d (byte %h)",
                                         o_data.field_tag, want.field_tag, want.byte_out));
                if (o_data.record_end !== want.record_end)
                    flag_error($sformatf("record_end %b, want %b (byte %h)",
                                         o_data.record_end, want.record_end, want.byte_out));
                if (o_data.record_status !== want.record_status)
                    flag_error($sformatf("record_status %b, want %b",
                                         o_data.record_status, want.record_status));
                if (o_data.sequence_length !== want.sequence_length)
                    flag_error($sformatf("sequence_length %0d, want %0d",
                                         o_data.sequence_length, want.sequence_length));
            end
        end
    end

    function automatic void add_byte(logic [7:0] b, logic eos);
        frp_pkg::t_in_beat t;
        t.data_byte = b;
        t.end_of_stream = eos;
        text_stream.push_back(t);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
    endfunction

    // LF, CR or CR LF
    function automatic void add_break();
        int r;
        r = $urandom_range(0, 2);
        if (r != 1) add_byte(frp_pkg::CH_CR, 1'b0);
        if (r != 0) add_byte(frp_pkg::CH_LF, 1'b0);
    endfunction

    function automatic logic [7:0] base_char();
        string s = "ACGTN";
        return s[$urandom_range(0, 4)];
    endfunction

    // One record; may carry end of stream on its last or a random byte, or be cut open
    function automatic void add_record(bit with_qual, bit leave_open);
        int start;
        int seq_n;
        int qual_n;
        int cut;
        int k;
        start = text_stream.size();
        add_byte(frp_pkg::CH_AT, 1'b0);
        repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(33, 126)), 1'b0);
        add_break();
        seq_n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 20);
        repeat (seq_n) add_byte(base_char(), 1'b0);
        add_break();
        add_byte("+", 1'b0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(33, 126)), 1'b0);
        add_break();
        if (with_qual) begin
            qual_n = seq_n;
            if ($urandom_range(0, 7) == 0) qual_n = seq_n + int'($urandom_range(0, 2)) - 1;
            if (qual_n < 0) qual_n = 1;
            repeat (qual_n) add_byte(8'($urandom_range(33, 126)), 1'b0);
            add_break();
        end
        k = $urandom_range(0, 19);
        if (leave_open || k == 0) begin
            cut = $urandom_range(start, text_stream.size() - 1);
            while (text_stream.size() > cut + 1) void'(text_stream.pop_back());
            if (!leave_open) text_stream[cut].end_of_stream = 1'b1;
        end else if (k == 1) begin
            text_stream[text_stream.size() - 1].end_of_stream = 1'b1;
        end
    endfunction

    // Wait until every byte is sent and every beat checked
    task automatic drain();
        while (text_stream.size() != 0 || i_valid || tagged_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Optional register write, then read back and compare
    task automatic cfg_access(input bit do_write, input bit v);
        logic [31:0] word;
        if (do_write) begin
            word = $urandom();
            word[0] = v;
            @(negedge i_clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= HASQ_ADDR;
            pwdata <= word;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            sh_has_qual = v;
        end
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= HASQ_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(sh_has_qual))
            flag_error($sformatf("has_quality reads %h, want %0d", prdata, sh_has_qual));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stimulus
    initial begin
        bit hq;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        cfg_access(1'b0, 1'b0);

        // Directed: skipped lines, '@' mid-line, CR LF pairs, CR CR and empty lines,
        // then a lone '@' that ends the stream
        add_text("x@\n\n@A\nGT\015\n+\015GC\n");
        add_text("@\015A\015\015");
        add_byte(frp_pkg::CH_AT, 1'b1);
        drain();
        cfg_access(1'b1, 1'b0);
        add_text("@\nAC\n+\n");
        drain();

        // Random rounds; a round may stop mid-record before the next register write
        for (int k = 0; k < 8; k++) begin
            hq = (k < 2) ? 1'(k) : 1'($urandom_range(0, 1));
            cfg_access(1'b1, hq);
            idle_on = (k % 4 != 3);
            while (text_stream.size() < 145) begin
                case ($urandom_range(0, 99)) inside
                    [0:74]: add_record(hq ^ ($urandom_range(0, 9) == 0), 1'b0);
                    [75:84]: begin
                        add_byte(8'($urandom_range(65, 126)), 1'b0);
                        repeat ($urandom_range(0, 6))
                            add_byte(8'($urandom_range(33, 126)), 1'b0);
                        add_break();
                    end
                    [85:91]: repeat ($urandom_range(1, 3)) add_break();
                    default: repeat ($urandom_range(1, 12))
                        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                endcase
            end
            if ($urandom_range(0, 1)) add_record(hq, 1'b1);
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (mism_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #25_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

### fastq_record_parser_core.f
rtl/frp_pkg.sv
rtl/frp_front.sv
rtl/frp_queue.sv
rtl/frp_back.sv
rtl/fastq_record_parser_core.sv
rtl/frp_checker.sv
verif/tb_top.sv
